// ===== hdl/animation_time_controller_assert.svh =====
// Assertion macros for animation_time_controller; clock i_clk, reset i_rst_n in scope.
`ifndef ANIMATION_TIME_CONTROLLER_ASSERT_SVH
`define ANIMATION_TIME_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define ATC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("animation_time_controller check failed");

// Next-cycle implication.
`define ATC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("animation_time_controller check failed");

`endif

// ===== hdl/atc_pkg.sv =====
`timescale 1ns / 1ps

package atc_pkg;

    localparam int ATC_MAX_MARKERS = 4;
    localparam int MARKER_SLOTS    = 4;
    localparam int MARKER_IDX_W    = $clog2(MARKER_SLOTS);
    localparam int CFG_DATA_W      = 64;

    typedef logic signed [31:0] t_time;
    typedef logic signed [47:0] t_product;
    typedef logic signed [3:0]  t_section;
    typedef logic [1:0]         t_op;
    typedef logic [1:0]         t_mode;
    typedef logic [2:0]         t_cfg_idx;

    localparam t_op OP_TICK        = 2'd0;
    localparam t_op OP_SET_SECTION = 2'd1;
    localparam t_op OP_SET_TIME    = 2'd2;

    localparam t_mode MODE_STOP    = 2'd0;
    localparam t_mode MODE_LOOP    = 2'd1;
    localparam t_mode MODE_REVERSE = 2'd2;
    localparam t_mode MODE_ONCE    = 2'd3;

    localparam t_cfg_idx CFG_PLAY_MODE    = 3'd0;
    localparam t_cfg_idx CFG_CLIP_START   = 3'd1;
    localparam t_cfg_idx CFG_CLIP_STOP    = 3'd2;
    localparam t_cfg_idx CFG_BASE_SCALE   = 3'd3;
    localparam t_cfg_idx CFG_MARKER_COUNT = 3'd4;
    localparam t_cfg_idx CFG_MARKERS_LOW  = 3'd5;
    localparam t_cfg_idx CFG_MARKERS_HIGH = 3'd6;

    localparam t_section SECTION_WHOLE = -4'sd1;
    localparam logic signed [15:0] SCALE_UNITY = 16'sd256;

    typedef struct packed {
        t_mode                      play_mode;
        t_time                      clip_start;
        t_time                      clip_stop;
        logic signed [15:0]         base_scale;
        logic [2:0]                 marker_count;
        logic [MARKER_SLOTS-1:0][31:0] markers;
    } t_cfg;

    typedef struct packed {
        t_op      op;
        t_time    value;
        t_section section;
        t_product product;
    } t_item;

    typedef struct packed {
        t_time    play_time;
        t_section section;
        logic     reversed;
    } t_state;

    function automatic logic signed [41:0] ext42(input logic signed [31:0] v);
        return {{10{v[31]}}, v};
    endfunction

    function automatic t_time sat32(input logic signed [41:0] v);
        if (v[41:31] == {11{v[41]}}) begin
            return v[31:0];
        end
        return v[41] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    endfunction

endpackage

// ===== hdl/atc_if.sv =====
`timescale 1ns / 1ps

interface atc_in_if;
    logic                valid;
    logic                ready;
    atc_pkg::t_op        op;
    atc_pkg::t_time      value;
    atc_pkg::t_section   section;

    modport source (output valid, output op, output value, output section, input ready);
    modport sink   (input valid, input op, input value, input section, output ready);
endinterface

interface atc_out_if;
    logic                valid;
    logic                ready;
    atc_pkg::t_time      play_time;
    atc_pkg::t_section   active_section;
    logic                reversed;
    atc_pkg::t_time      bound_start;
    atc_pkg::t_time      bound_stop;

    modport source (output valid, output play_time, output active_section, output reversed,
                    output bound_start, output bound_stop, input ready);
    modport sink   (input valid, input play_time, input active_section, input reversed,
                    input bound_start, input bound_stop, output ready);
endinterface

// ===== hdl/atc_front.sv =====
`timescale 1ns / 1ps

module atc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    atc_in_if.sink             i_in,
    input  logic signed [15:0] i_base_scale,
    input  logic               i_advance,
    output logic               o_valid,
    output atc_pkg::t_item     o_item
);
    import atc_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_item    r_item;
    logic     ready;
    logic     accept;
    t_product n_product;

    assign ready      = !r_valid || i_advance;
    assign i_in.ready = ready;
    assign accept     = i_in.valid && ready;
    assign n_product  = t_product'(i_base_scale) * t_product'(i_in.value);

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op      <= i_in.op;
            r_item.value   <= i_in.value;
            r_item.section <= i_in.section;
            r_item.product <= n_product;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hdl/atc_step.sv =====
`timescale 1ns / 1ps

module atc_step #(
    parameter int MaxMarkers = atc_pkg::ATC_MAX_MARKERS
) (
    input  atc_pkg::t_item  i_item,
    input  atc_pkg::t_state i_state,
    input  atc_pkg::t_cfg   i_cfg,
    output atc_pkg::t_state o_state,
    output atc_pkg::t_time  o_bound_start,
    output atc_pkg::t_time  o_bound_stop
);
    import atc_pkg::*;

    logic [2:0]          cnt;
    t_section            cnt_s;
    t_section            sec_old;
    t_section            sec_new;
    t_time               lo;
    t_time               hi;
    logic signed [48:0]  prod_ext;
    logic signed [48:0]  scaled;
    logic signed [40:0]  delta_q;
    t_time               t0;
    t_time               t1;
    t_time               t2;
    logic                flip_lo;
    logic                flip_hi;
    t_time               set_t;
    t_time               n_time;
    logic                n_rev;

    function automatic t_section clamp_sec(input t_section req, input t_section n);
        if (req < SECTION_WHOLE || n == 4'sd0) begin
            return SECTION_WHOLE;
        end
        if (req > n) begin
            return n;
        end
        return req;
    endfunction

    function automatic t_time marker_at(input logic [2:0] idx);
        if (int'(idx) >= MaxMarkers) begin
            return '0;
        end
        return i_cfg.markers[idx[MARKER_IDX_W-1:0]];
    endfunction

    assign cnt     = (int'(i_cfg.marker_count) > MaxMarkers) ? 3'(MaxMarkers)
                                                             : i_cfg.marker_count;
    assign cnt_s   = $signed({1'b0, cnt});
    assign sec_old = clamp_sec(i_state.section, cnt_s);
    assign sec_new = (i_item.op == OP_SET_SECTION) ? clamp_sec(i_item.section, cnt_s)
                                                   : sec_old;

    assign lo = (sec_new == SECTION_WHOLE || sec_new == 4'sd0) ? i_cfg.clip_start
                                                               : marker_at(sec_new[2:0] - 3'd1);
    assign hi = (sec_new == SECTION_WHOLE || sec_new == cnt_s) ? i_cfg.clip_stop
                                                               : marker_at(sec_new[2:0]);

    // floor of scale * delta / 256
    assign prod_ext = {i_item.product[47], i_item.product};
    assign scaled   = i_state.reversed ? -prod_ext : prod_ext;
    assign delta_q  = scaled[48:8];
    assign t0       = sat32(ext42(i_state.play_time) + {delta_q[40], delta_q});

    always_comb begin
        t1      = t0;
        flip_lo = 1'b0;
        if (t0 < lo) begin
            case (i_cfg.play_mode)
                MODE_LOOP: t1 = sat32(ext42(hi) - ext42(lo) + ext42(t0));
                MODE_REVERSE: begin
                    t1      = sat32(ext42(lo) + ext42(lo) - ext42(t0));
                    flip_lo = 1'b1;
                end
                default: t1 = lo;
            endcase
        end
    end

    always_comb begin
        t2      = t1;
        flip_hi = 1'b0;
        if (t1 > hi) begin
            case (i_cfg.play_mode)
                MODE_LOOP: t2 = sat32(ext42(lo) + ext42(t1) - ext42(hi));
                MODE_REVERSE: begin
                    t2      = sat32(ext42(hi) + ext42(hi) - ext42(t1));
                    flip_hi = 1'b1;
                end
                default: t2 = hi;
            endcase
        end
    end

    assign set_t = (i_item.value < lo) ? lo : ((i_item.value > hi) ? hi : i_item.value);

    always_comb begin
        n_time = i_state.play_time;
        n_rev  = i_state.reversed;
        case (i_item.op)
            OP_TICK: begin
                if (i_cfg.play_mode != MODE_STOP) begin
                    n_time = t2;
                    n_rev  = i_state.reversed ^ flip_lo ^ flip_hi;
                end
            end
            OP_SET_SECTION: n_time = lo;
            OP_SET_TIME:    n_time = set_t;
            default: ;
        endcase
    end

    assign o_state.play_time = n_time;
    assign o_state.section   = sec_new;
    assign o_state.reversed  = n_rev;
    assign o_bound_start     = lo;
    assign o_bound_stop      = hi;

endmodule

// ===== hdl/animation_time_controller.sv =====
// Pipeline: the input stage registers an accepted word, the step stage registers its
// result. Throughput: one word per cycle unless o_out.ready stalls; the playback-state
// update loop closes in the single step stage, with the scale multiply done ahead of it
// in the input stage. Reset (i_rst_n low, synchronous): both stages empty, configuration
// at defaults, time 0, section -1 (whole clip), direction forward.
`timescale 1ns / 1ps

module animation_time_controller #(
    parameter int MaxMarkers = atc_pkg::ATC_MAX_MARKERS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  atc_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [atc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    atc_in_if.sink                            i_in,
    atc_out_if.source                         o_out
);
    import atc_pkg::*;

`include "animation_time_controller_assert.svh"

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_time  r_lo;
    t_time  r_hi;
    t_time  n_lo;
    t_time  n_hi;
    logic   s1_valid;
    t_item  s1_item;
    logic   advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.play_mode    <= MODE_LOOP;
            r_cfg.clip_start   <= '0;
            r_cfg.clip_stop    <= '0;
            r_cfg.base_scale   <= SCALE_UNITY;
            r_cfg.marker_count <= '0;
            r_cfg.markers      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PLAY_MODE:    r_cfg.play_mode    <= i_cfg_data[1:0];
                CFG_CLIP_START:   r_cfg.clip_start   <= i_cfg_data[31:0];
                CFG_CLIP_STOP:    r_cfg.clip_stop    <= i_cfg_data[31:0];
                CFG_BASE_SCALE:   r_cfg.base_scale   <= i_cfg_data[15:0];
                CFG_MARKER_COUNT: r_cfg.marker_count <= i_cfg_data[2:0];
                CFG_MARKERS_LOW: begin
                    r_cfg.markers[0] <= i_cfg_data[31:0];
                    r_cfg.markers[1] <= i_cfg_data[63:32];
                end
                CFG_MARKERS_HIGH: begin
                    r_cfg.markers[2] <= i_cfg_data[31:0];
                    r_cfg.markers[3] <= i_cfg_data[63:32];
                end
                default: ;
            endcase
        end
    end

    assign advance = s1_valid && (!r_out_valid || o_out.ready);

    atc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_base_scale (r_cfg.base_scale),
        .i_advance    (advance),
        .o_valid      (s1_valid),
        .o_item       (s1_item)
    );

    atc_step #(
        .MaxMarkers (MaxMarkers)
    ) u_step (
        .i_item        (s1_item),
        .i_state       (r_state),
        .i_cfg         (r_cfg),
        .o_state       (n_state),
        .o_bound_start (n_lo),
        .o_bound_stop  (n_hi)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_state.play_time <= '0;
            r_state.section   <= SECTION_WHOLE;
            r_state.reversed  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.play_time      = r_state.play_time;
    assign o_out.active_section = r_state.section;
    assign o_out.reversed       = r_state.reversed;
    assign o_out.bound_start    = r_lo;
    assign o_out.bound_stop     = r_hi;

    `ATC_ASSERT_NOW(a_section_range, 1'b1, (r_state.section == SECTION_WHOLE) || ((r_state.section >= 4'sd0) && (int'(r_state.section) <= MaxMarkers)))
    `ATC_ASSERT_NEXT(a_stall_holds, r_out_valid && !o_out.ready, r_out_valid && $stable(r_state))
    `ATC_ASSERT_NEXT(a_stop_tick_keeps_time, advance && (s1_item.op == OP_TICK) && (r_cfg.play_mode == MODE_STOP), r_state.play_time == $past(r_state.play_time))

endmodule
